[rtl/ufdm_pkg.sv]
// ----------------------------------------------------------------------------
// ufdm_pkg
// Shared types and constants of the disjoint-set table with diameter merge.
// ----------------------------------------------------------------------------
`default_nettype none

package ufdm_pkg;

  localparam int unsigned NODES    = 1024;
  localparam int unsigned IDX_W    = $clog2(NODES);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned DIAM_W   = 10;
  localparam int unsigned DIAM_MAX = (1 << DIAM_W) - 1;
  // The merged-diameter term saturates at the smaller of NODES-1 and DIAM_MAX.
  localparam int unsigned SAT_LIMIT = (NODES - 1 > DIAM_MAX) ? DIAM_MAX : NODES - 1;
  localparam logic [DIAM_W-1:0] DIAM_SAT = DIAM_W'(SAT_LIMIT);

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_JOIN  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_SET   = 2'd3
  } cmd_e;

  typedef enum logic {
    PR_START = 1'b0,
    PR_NEXT  = 1'b1
  } pr_src_e;

  typedef enum logic {
    DR_ROOT = 1'b0,
    DR_RA   = 1'b1
  } dr_src_e;

  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_DIAM   = 2'd1,
    RES_MERGED = 2'd2,
    RES_SAME   = 2'd3
  } res_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [DIAM_W-1:0] diameter_value;
  } ufdm_in_t;

  typedef struct packed {
    logic [DIAM_W-1:0] diameter_out;
    logic              flag;
  } ufdm_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic    clr_en;
    logic    in_load;
    logic    use_b;
    pr_src_e pr_src;
    logic    root_load;
    logic    ra_load;
    logic    comp_we;
    logic    diam_re;
    dr_src_e dr_src;
    logic    da_load;
    logic    set_we;
    logic    merge_we;
    logic    res_load;
    res_e    res_kind;
  } ufdm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    cmd_e cmd;
    logic a_ok;
    logic b_ok;
    logic walk_root;
    logic start_root;
    logic comp_end;
    logic same_root;
    logic out_free;
  } ufdm_sts_t;

endpackage

`default_nettype wire

[rtl/ufdm_dp.sv]
// ----------------------------------------------------------------------------
// ufdm_dp
// Datapath: parent and diameter memories, walk registers, merge arithmetic,
// clearing counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufdm_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ufdm_pkg::ufdm_in_t  in_data_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output ufdm_pkg::ufdm_out_t    out_data_o,
  input  wire ufdm_pkg::ufdm_cmd_t cmd_i,
  output ufdm_pkg::ufdm_sts_t    sts_o
);

  logic [ufdm_pkg::IDX_W-1:0]  par_mem  [ufdm_pkg::NODES];
  logic [ufdm_pkg::DIAM_W-1:0] diam_mem [ufdm_pkg::NODES];

  ufdm_pkg::ufdm_in_t          in_q;
  logic [ufdm_pkg::IDX_W-1:0]  last_q, prd_q, root_q, ra_q;
  logic [ufdm_pkg::DIAM_W-1:0] drd_q, da_q;
  logic [ufdm_pkg::CNT_W-1:0]  clr_cnt_q;
  logic                        out_valid_q;
  ufdm_pkg::ufdm_out_t         out_q;

  logic [ufdm_pkg::IDX_W-1:0]  idx_a, idx_b, start, praddr, draddr, clr_idx;
  logic                        pwe, dwe;
  logic [ufdm_pkg::IDX_W-1:0]  pwa, pwd, dwa;
  logic [ufdm_pkg::DIAM_W-1:0] dwd, merged;
  logic [ufdm_pkg::DIAM_W:0]   half_a, half_b;
  logic [ufdm_pkg::DIAM_W+1:0] cand;
  logic [ufdm_pkg::DIAM_W-1:0] cand_sat, dmax;
  logic                        same_root;

  assign idx_a   = ufdm_pkg::IDX_W'(in_q.node_a);
  assign idx_b   = ufdm_pkg::IDX_W'(in_q.node_b);
  assign clr_idx = clr_cnt_q[ufdm_pkg::IDX_W-1:0];
  assign start   = cmd_i.use_b ? idx_b : idx_a;
  assign praddr  = (cmd_i.pr_src == ufdm_pkg::PR_NEXT) ? prd_q : start;
  assign draddr  = (cmd_i.dr_src == ufdm_pkg::DR_RA) ? ra_q : root_q;
  assign same_root = (ra_q == root_q);

  // Merged diameter: max(da, db, min(ceil(da/2) + ceil(db/2) + 1, limit)).
  // At the merge step da sits in da_q and db has just arrived in drd_q.
  always_comb begin
    half_a = ((ufdm_pkg::DIAM_W+1)'(da_q) + (ufdm_pkg::DIAM_W+1)'(1)) >> 1;
    half_b = ((ufdm_pkg::DIAM_W+1)'(drd_q) + (ufdm_pkg::DIAM_W+1)'(1)) >> 1;
    cand   = (ufdm_pkg::DIAM_W+2)'(half_a) + (ufdm_pkg::DIAM_W+2)'(half_b)
           + (ufdm_pkg::DIAM_W+2)'(1);
    cand_sat = (cand > (ufdm_pkg::DIAM_W+2)'(ufdm_pkg::SAT_LIMIT)) ?
               ufdm_pkg::DIAM_SAT : cand[ufdm_pkg::DIAM_W-1:0];
    dmax   = (da_q > drd_q) ? da_q : drd_q;
    merged = (cand_sat > dmax) ? cand_sat : dmax;
  end

  always_comb begin
    pwe = 1'b1;
    pwa = clr_idx;
    pwd = clr_idx;
    priority if (cmd_i.clr_en) begin
      pwa = clr_idx;
      pwd = clr_idx;
    end else if (cmd_i.comp_we) begin
      pwa = last_q;
      pwd = root_q;
    end else if (cmd_i.merge_we) begin
      pwa = root_q;
      pwd = ra_q;
    end else begin
      pwe = 1'b0;
    end
  end

  always_comb begin
    dwe = 1'b1;
    dwa = clr_idx;
    dwd = '0;
    priority if (cmd_i.clr_en) begin
      dwa = clr_idx;
      dwd = '0;
    end else if (cmd_i.set_we) begin
      dwa = idx_a;
      dwd = in_q.diameter_value;
    end else if (cmd_i.merge_we) begin
      dwa = ra_q;
      dwd = merged;
    end else begin
      dwe = 1'b0;
    end
  end

  // Both memories have one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (pwe) begin
      par_mem[pwa] <= pwd;
    end
    prd_q  <= par_mem[praddr];
    last_q <= praddr;
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      diam_mem[dwa] <= dwd;
    end
    if (cmd_i.diam_re) begin
      drd_q <= diam_mem[draddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.root_load) begin
      root_q <= last_q;
    end
    if (cmd_i.ra_load) begin
      ra_q <= root_q;
    end
    if (cmd_i.da_load) begin
      da_q <= drd_q;
    end
    if (cmd_i.res_load) begin
      out_q.diameter_out <= (cmd_i.res_kind == ufdm_pkg::RES_DIAM) ? drd_q : '0;
      out_q.flag         <= (cmd_i.res_kind == ufdm_pkg::RES_MERGED) ||
                            ((cmd_i.res_kind == ufdm_pkg::RES_SAME) && same_root);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + ufdm_pkg::CNT_W'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.clr_done   = cmd_i.clr_en &&
                       (clr_cnt_q == ufdm_pkg::CNT_W'(ufdm_pkg::NODES - 1));
    sts_o.cmd        = in_q.cmd;
    sts_o.a_ok       = (32'(in_q.node_a) < ufdm_pkg::NODES);
    sts_o.b_ok       = (32'(in_q.node_b) < ufdm_pkg::NODES);
    sts_o.walk_root  = (prd_q == last_q);
    sts_o.start_root = (start == last_q);
    sts_o.comp_end   = (prd_q == root_q);
    sts_o.same_root  = same_root;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/ufdm_ctrl.sv]
// ----------------------------------------------------------------------------
// ufdm_ctrl
// Command sequencer: clearing pass, two-phase find with path compression,
// join and query steps, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ufdm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output ufdm_pkg::ufdm_cmd_t      cmd_o,
  input  wire ufdm_pkg::ufdm_sts_t sts_i
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_FSTART   = 4'd3;
  localparam logic [3:0] S_WALK     = 4'd4;
  localparam logic [3:0] S_COMP     = 4'd5;
  localparam logic [3:0] S_QRD      = 4'd6;
  localparam logic [3:0] S_JCMP     = 4'd7;
  localparam logic [3:0] S_JRDB     = 4'd8;
  localparam logic [3:0] S_MERGE    = 4'd9;
  localparam logic [3:0] S_RESULT   = 4'd10;

  logic [3:0]     state_q, state_d;
  logic           phase_q, phase_d;
  ufdm_pkg::res_e kind_q, kind_d;

  // Where to go once a find has reached its root and compressed its path.
  logic [3:0]     fd_state;
  logic           fd_phase;
  ufdm_pkg::res_e fd_kind;

  always_comb begin
    fd_state = S_RESULT;
    fd_phase = phase_q;
    fd_kind  = ufdm_pkg::RES_ZERO;
    unique case (sts_i.cmd)
      ufdm_pkg::CMD_QUERY: fd_state = S_QRD;
      ufdm_pkg::CMD_JOIN: begin
        if (!phase_q) begin
          fd_state = S_FSTART;
          fd_phase = 1'b1;
        end else begin
          fd_state = S_JCMP;
        end
      end
      ufdm_pkg::CMD_CHECK: begin
        if (!phase_q) begin
          fd_state = S_FSTART;
          fd_phase = 1'b1;
        end else begin
          fd_state = S_RESULT;
          fd_kind  = ufdm_pkg::RES_SAME;
        end
      end
      default: fd_state = S_RESULT;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.use_b    = phase_q;
    cmd_o.pr_src   = ufdm_pkg::PR_START;
    cmd_o.dr_src   = ufdm_pkg::DR_ROOT;
    cmd_o.res_kind = kind_q;
    in_ready_o     = 1'b0;
    state_d        = state_q;
    phase_d        = phase_q;
    kind_d         = kind_q;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        phase_d = 1'b0;
        kind_d  = ufdm_pkg::RES_ZERO;
        unique case (sts_i.cmd)
          ufdm_pkg::CMD_SET: begin
            cmd_o.set_we = sts_i.a_ok;
            state_d      = S_RESULT;
          end
          ufdm_pkg::CMD_QUERY: begin
            state_d = sts_i.a_ok ? S_FSTART : S_RESULT;
          end
          default: begin
            state_d = (sts_i.a_ok && sts_i.b_ok) ? S_FSTART : S_RESULT;
          end
        endcase
      end
      S_FSTART: begin
        // Entering the second find, the first root is still in the root register.
        cmd_o.ra_load = phase_q;
        state_d       = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_root) begin
          cmd_o.root_load = 1'b1;
          if (sts_i.start_root) begin
            state_d = fd_state;
            phase_d = fd_phase;
            kind_d  = fd_kind;
          end else begin
            state_d = S_COMP;
          end
        end else begin
          cmd_o.pr_src = ufdm_pkg::PR_NEXT;
        end
      end
      S_COMP: begin
        cmd_o.comp_we = 1'b1;
        if (sts_i.comp_end) begin
          state_d = fd_state;
          phase_d = fd_phase;
          kind_d  = fd_kind;
        end else begin
          cmd_o.pr_src = ufdm_pkg::PR_NEXT;
        end
      end
      S_QRD: begin
        cmd_o.diam_re = 1'b1;
        kind_d        = ufdm_pkg::RES_DIAM;
        state_d       = S_RESULT;
      end
      S_JCMP: begin
        if (sts_i.same_root) begin
          kind_d  = ufdm_pkg::RES_ZERO;
          state_d = S_RESULT;
        end else begin
          cmd_o.diam_re = 1'b1;
          cmd_o.dr_src  = ufdm_pkg::DR_RA;
          state_d       = S_JRDB;
        end
      end
      S_JRDB: begin
        cmd_o.da_load = 1'b1;
        cmd_o.diam_re = 1'b1;
        state_d       = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge_we = 1'b1;
        kind_d         = ufdm_pkg::RES_MERGED;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= 1'b0;
      kind_q  <= ufdm_pkg::RES_ZERO;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

[rtl/union_find_with_diameter_merge.sv]
// ----------------------------------------------------------------------------
// union_find_with_diameter_merge
// Disjoint-set table of 1024 elements with per-set diameter and merge rule.
// ----------------------------------------------------------------------------
// Usage: a command transaction on the input channel (valid/ready) carries
// cmd, node_a, node_b and diameter_value; exactly one result transaction
// (diameter_out, flag) follows on the output channel for every command.
// After reset the block runs a clearing pass that points each element at
// itself and zeroes every diameter; in_ready_o stays low until it is done.
// One command is worked at a time, limited by the single read port of the
// parent memory: a find reads its way up the links to the root and then
// rewrites the links on the walked path to point at the root. in_ready_o
// rises the cycle after the result is loaded. If the receiver stalls, the
// result waits in the output register and a finished command holds there
// until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_with_diameter_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ufdm_pkg::ufdm_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ufdm_pkg::ufdm_out_t       out_data_o
);

  ufdm_pkg::ufdm_cmd_t cmd;
  ufdm_pkg::ufdm_sts_t sts;

  ufdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ufdm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTH
  // A result is never loaded over one that the receiver has not taken.
  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  // No table write happens while the block is waiting for a command.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.comp_we || cmd.merge_we || cmd.set_we))
    else $error("table write while idle");

  // A merge only links two distinct roots.
  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.merge_we |-> !sts.same_root)
    else $error("merge of a set with itself");

  // Commands are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second command accepted while one is in progress");
`endif

endmodule

`default_nettype wire

[test/union_find_with_diameter_merge_tb.sv]
// ----------------------------------------------------------------------------
// union_find_with_diameter_merge_tb
// Self-checking testbench of the disjoint-set table with diameter merge.
// ----------------------------------------------------------------------------
// A driver feeds commands from a backlog with random bursts and gaps, while
// the receiver stalls on a pattern of its own, once for a long stretch. Each
// accepted command updates a local copy of the parent and diameter tables,
// and the predicted result is queued. Each result transaction is compared
// field by field with the oldest prediction. A short directed part covers the
// field extremes, every command, saturation of the merged diameter, joins
// inside one set and diameter writes to non-root elements. Three random
// phases follow over small element pools with some full-range noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_with_diameter_merge_tb;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 645;
  localparam int unsigned MERGE_LIMIT    =
    (ufdm_pkg::NODES - 1 > 1023) ? 1023 : ufdm_pkg::NODES - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  ufdm_pkg::ufdm_in_t  in_data = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  ufdm_pkg::ufdm_out_t out_data_o;

  union_find_with_diameter_merge i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  // Local copy of the table state.
  logic [ufdm_pkg::NODE_W-1:0] link_tbl [ufdm_pkg::NODES];
  logic [ufdm_pkg::DIAM_W-1:0] diam_tbl [ufdm_pkg::NODES];

  ufdm_pkg::ufdm_in_t  cmd_backlog [$];
  ufdm_pkg::ufdm_out_t pending_results [$];

  int unsigned mismatches = 0;
  int unsigned n_query = 0, n_join = 0, n_merged = 0, n_check = 0, n_same = 0;
  int unsigned n_set = 0, n_saturated = 0, max_diam = 0;

  // Random pool that the current phase draws most elements from.
  int unsigned pool_base = 0;
  int unsigned pool_span = 47;
  int unsigned noise_pct = 10;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ufdm_pkg::NODE_W-1:0] root_of(
    logic [ufdm_pkg::NODE_W-1:0] x);
    logic [ufdm_pkg::NODE_W-1:0] r;
    logic [ufdm_pkg::NODE_W-1:0] nxt;
    int unsigned steps;
    r = x;
    steps = 0;
    while (link_tbl[r] != r && steps < ufdm_pkg::NODES) begin
      r = link_tbl[r];
      steps++;
    end
    // Point every element on the walked path straight at the root.
    steps = 0;
    while (x != r && steps < ufdm_pkg::NODES) begin
      nxt = link_tbl[x];
      link_tbl[x] = r;
      x = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic ufdm_pkg::ufdm_out_t apply_command(ufdm_pkg::ufdm_in_t c);
    ufdm_pkg::ufdm_out_t res;
    logic [ufdm_pkg::NODE_W-1:0] ra;
    logic [ufdm_pkg::NODE_W-1:0] rb;
    int unsigned da, db, cand, m;
    bit a_ok, b_ok;
    res = '0;
    a_ok = int'(c.node_a) < ufdm_pkg::NODES;
    b_ok = int'(c.node_b) < ufdm_pkg::NODES;
    case (c.cmd)
      ufdm_pkg::CMD_QUERY: begin
        n_query++;
        if (a_ok) res.diameter_out = diam_tbl[root_of(c.node_a)];
      end
      ufdm_pkg::CMD_JOIN: begin
        n_join++;
        if (a_ok && b_ok) begin
          ra = root_of(c.node_a);
          rb = root_of(c.node_b);
          if (ra != rb) begin
            da = diam_tbl[ra];
            db = diam_tbl[rb];
            cand = ((da + 1) >> 1) + ((db + 1) >> 1) + 1;
            if (cand > MERGE_LIMIT) begin
              cand = MERGE_LIMIT;
              n_saturated++;
            end
            m = (da > db) ? da : db;
            if (cand > m) m = cand;
            diam_tbl[ra] = ufdm_pkg::DIAM_W'(m);
            link_tbl[rb] = ra;
            res.flag = 1'b1;
            n_merged++;
            if (m > max_diam) max_diam = m;
          end
        end
      end
      ufdm_pkg::CMD_CHECK: begin
        n_check++;
        if (a_ok && b_ok) begin
          res.flag = (root_of(c.node_a) == root_of(c.node_b));
          if (res.flag) n_same++;
        end
      end
      default: begin
        n_set++;
        // The value lands on the element itself, root or not.
        if (a_ok) diam_tbl[c.node_a] = c.diameter_value;
      end
    endcase
    return res;
  endfunction

  task automatic push_cmd(ufdm_pkg::cmd_e c, int unsigned a, int unsigned b,
                          int unsigned v);
    ufdm_pkg::ufdm_in_t item;
    item.cmd = c;
    item.node_a = ufdm_pkg::NODE_W'(a);
    item.node_b = ufdm_pkg::NODE_W'(b);
    item.diameter_value = ufdm_pkg::DIAM_W'(v);
    cmd_backlog = {cmd_backlog, item};
  endtask

  function automatic int unsigned pick_node();
    if ($urandom_range(0, 99) < 80) return pool_base + $urandom_range(0, pool_span);
    return $urandom_range(0, ufdm_pkg::NODES - 1);
  endfunction

  task automatic push_random_cmd();
    int unsigned r;
    int unsigned v;
    ufdm_pkg::ufdm_in_t item;
    if ($urandom_range(0, 99) < noise_pct) begin
      item = ufdm_pkg::ufdm_in_t'($urandom);
      cmd_backlog = {cmd_backlog, item};
    end else begin
      r = $urandom_range(0, 99);
      v = $urandom_range(0, 99);
      if (v < 70) v = $urandom_range(0, 40);
      else if (v < 90) v = $urandom_range(0, 1023);
      else v = 1023;
      if (r < 35) push_cmd(ufdm_pkg::CMD_JOIN, pick_node(), pick_node(),
                           $urandom_range(0, 1023));
      else if (r < 60) push_cmd(ufdm_pkg::CMD_QUERY, pick_node(), $urandom_range(0, 1023),
                                $urandom_range(0, 1023));
      else if (r < 80) push_cmd(ufdm_pkg::CMD_CHECK, pick_node(), pick_node(),
                                $urandom_range(0, 1023));
      else push_cmd(ufdm_pkg::CMD_SET, pick_node(), $urandom_range(0, 1023), v);
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: bursts of random length with random gaps between them.
  logic        in_fire_q = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire_q)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= cmd_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left <= 0;
            9:          gap_left <= $urandom_range(10, 30);
            default:    gap_left <= $urandom_range(1, 8);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern in modes of random length, plus one long hold-off.
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Prediction on each accepted command, checking on each accepted result.
  always @(posedge clk_i) begin
    ufdm_pkg::ufdm_out_t want;
    in_fire_q <= in_valid && in_ready_o;
    if (in_valid && in_ready_o) begin
      want = apply_command(in_data);
      pending_results = {pending_results, want};
    end
    if (out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got diameter_out=%0d flag=%0b",
                 $time, out_data_o.diameter_out, out_data_o.flag);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.diameter_out !== want.diameter_out) begin
          mismatches++;
          $display("%0t: diameter_out mismatch, expected %0d, got %0d",
                   $time, want.diameter_out, out_data_o.diameter_out);
        end
        if (out_data_o.flag !== want.flag) begin
          mismatches++;
          $display("%0t: flag mismatch, expected %0b, got %0b",
                   $time, want.flag, out_data_o.flag);
        end
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles, %0d results pending",
               $time, idle_cycles, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ufdm_pkg::NODES; i++) begin
      link_tbl[i] = ufdm_pkg::NODE_W'(i);
      diam_tbl[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed commands.
    push_cmd(ufdm_pkg::CMD_QUERY, 0, 0, 0);
    push_cmd(ufdm_pkg::CMD_QUERY, 1023, 1023, 1023);
    push_cmd(ufdm_pkg::CMD_SET, 1023, 0, 1023);
    push_cmd(ufdm_pkg::CMD_SET, 1022, 1023, 1023);
    // Both diameters at the top: the merged term saturates.
    push_cmd(ufdm_pkg::CMD_JOIN, 1023, 1022, 0);
    push_cmd(ufdm_pkg::CMD_QUERY, 1022, 0, 0);
    push_cmd(ufdm_pkg::CMD_JOIN, 1022, 1023, 0);
    push_cmd(ufdm_pkg::CMD_JOIN, 5, 5, 0);
    push_cmd(ufdm_pkg::CMD_CHECK, 1022, 1023, 0);
    push_cmd(ufdm_pkg::CMD_CHECK, 0, 1023, 0);
    push_cmd(ufdm_pkg::CMD_CHECK, 7, 7, 0);
    push_cmd(ufdm_pkg::CMD_JOIN, 1, 2, 0);
    // Element 2 is no longer a root, so the query still sees the root's value.
    push_cmd(ufdm_pkg::CMD_SET, 2, 0, 500);
    push_cmd(ufdm_pkg::CMD_QUERY, 2, 0, 0);
    push_cmd(ufdm_pkg::CMD_SET, 3, 0, 7);
    push_cmd(ufdm_pkg::CMD_JOIN, 3, 1, 0);
    push_cmd(ufdm_pkg::CMD_CHECK, 2, 3, 0);
    push_cmd(ufdm_pkg::CMD_QUERY, 1, 0, 0);
    push_cmd(ufdm_pkg::CMD_SET, 4, 0, 1000);
    push_cmd(ufdm_pkg::CMD_SET, 6, 0, 998);
    push_cmd(ufdm_pkg::CMD_JOIN, 4, 6, 0);
    push_cmd(ufdm_pkg::CMD_QUERY, 6, 0, 0);
    push_cmd(ufdm_pkg::CMD_SET, 1021, 1023, 1023);
    push_cmd(ufdm_pkg::CMD_QUERY, 1021, 0, 0);
    wait_drained();

    // Dense pool at the bottom of the table; the receiver holds off meanwhile.
    pool_base = 0;
    pool_span = 47;
    noise_pct = 10;
    repeat (PHASE_ITEMS) push_random_cmd();
    repeat (50) @(posedge clk_i);
    hold_req = 1'b1;
    wait_drained();

    // Small pool gives deep sets and many same-set joins.
    pool_base = 512;
    pool_span = 15;
    noise_pct = 5;
    repeat (PHASE_ITEMS) push_random_cmd();
    wait_drained();

    // Wider pool at the top of the table with more full-range noise.
    pool_base = 960;
    pool_span = 63;
    noise_pct = 25;
    repeat (PHASE_ITEMS) push_random_cmd();
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("Ran %0d commands: %0d queries, %0d joins (%0d merged), %0d checks (%0d same).",
             n_query + n_join + n_check + n_set, n_query, n_join, n_merged, n_check,
             n_same);
    $display("Ran %0d diameter writes, %0d saturated merges, largest merged diameter %0d.",
             n_set, n_saturated, max_diam);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
